@@ rtl/core/opx_pkg.sv @@
// Package for the one-bit bitmap pixel expander.
// Holds store sizing, field and register types, and the codes used across the modules.
// Depends on nothing.
`default_nettype none
package opx_pkg;

    localparam int unsigned STORE_BYTES = 8192;
    localparam int unsigned MAX_WIDTH   = 512;
    localparam int unsigned ADDR_W      = $clog2(STORE_BYTES);

    // Widest row base plus column index, fixed by the coordinate and width field widths.
    localparam int unsigned SUM_W       = 18;
    localparam int unsigned CFG_DATA_W  = 10;
    localparam int unsigned CFG_INDEX_W = 3;

    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    localparam logic [1:0] LAYOUT_RASTER_MSB = 2'd0;
    localparam logic [1:0] LAYOUT_RASTER_LSB = 2'd1;
    localparam logic [1:0] LAYOUT_SCREEN     = 2'd2;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_IMAGE_WIDTH   = 3'd0,
        CFG_IMAGE_HEIGHT  = 3'd1,
        CFG_PIXEL_DOUBLE  = 3'd2,
        CFG_SOURCE_LAYOUT = 3'd3,
        CFG_FG_COLOUR     = 3'd4,
        CFG_BG_COLOUR     = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic        func;
        logic [12:0] byte_address;
        logic [7:0]  byte_value;
        logic [8:0]  pixel_x;
        logic [8:0]  pixel_y;
    } t_in_item;

    typedef struct packed {
        logic [7:0] colour;
        logic       bit_set;
        logic       out_of_range;
    } t_out_item;

    typedef struct packed {
        logic [9:0] image_width;
        logic [9:0] image_height;
        logic       pixel_doubling;
        logic [1:0] source_layout;
        logic [7:0] foreground_colour;
        logic [7:0] background_colour;
    } t_cfg;

    // Request after address generation: the final address is base plus col.
    typedef struct packed {
        logic             func;
        logic [SUM_W-1:0] base;
        logic [5:0]       col;
        logic [2:0]       bit_pos;
        logic             coord_oor;
        logic [7:0]       value;
    } t_s1;

    typedef struct packed {
        logic              we;
        logic              re;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        wdata;
    } t_mem_req;

endpackage
`default_nettype wire

@@ rtl/core/opx_cfg.sv @@
// Configuration register file of the pixel expander.
// Depends on opx_pkg for the register index codes and the t_cfg struct.
`default_nettype none
module opx_cfg
    import opx_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_data,
    output t_cfg                        o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.image_width       <= 10'd256;
            r_cfg.image_height      <= 10'd192;
            r_cfg.pixel_doubling    <= 1'b0;
            r_cfg.source_layout     <= LAYOUT_RASTER_MSB;
            r_cfg.foreground_colour <= 8'd0;
            r_cfg.background_colour <= 8'd7;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_IMAGE_WIDTH:   r_cfg.image_width       <= i_cfg_data;
                CFG_IMAGE_HEIGHT:  r_cfg.image_height      <= i_cfg_data;
                CFG_PIXEL_DOUBLE:  r_cfg.pixel_doubling    <= i_cfg_data[0];
                CFG_SOURCE_LAYOUT: r_cfg.source_layout     <= i_cfg_data[1:0];
                CFG_FG_COLOUR:     r_cfg.foreground_colour <= i_cfg_data[7:0];
                CFG_BG_COLOUR:     r_cfg.background_colour <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule
`default_nettype wire

@@ rtl/core/opx_addr.sv @@
// Address generator: turns a request into a row base, column byte and bit position.
// Depends on opx_pkg for the request, configuration and stage types.
`default_nettype none
module opx_addr
    import opx_pkg::*;
(
    input  wire t_in_item i_item,
    input  wire t_cfg     i_cfg,
    output t_s1           o_s1
);

    logic [9:0]  eff_width;
    logic [10:0] width_sum;
    logic [7:0]  per_row;
    logic [8:0]  sx;
    logic [8:0]  sy;
    logic [16:0] raster_base;
    logic [13:0] screen_base;
    logic        coord_oor;

    always_comb begin
        eff_width = (32'(i_cfg.image_width) > MAX_WIDTH) ? 10'(MAX_WIDTH)
                                                         : i_cfg.image_width;
        coord_oor = ({1'b0, i_item.pixel_x} >= eff_width) ||
                    ({1'b0, i_item.pixel_y} >= i_cfg.image_height);

        sx = i_cfg.pixel_doubling ? {1'b0, i_item.pixel_x[8:1]} : i_item.pixel_x;
        sy = i_cfg.pixel_doubling ? {1'b0, i_item.pixel_y[8:1]} : i_item.pixel_y;

        // Bytes per source row, rounded up for plain rows; a doubled row covers sixteen output pixels.
        if (i_cfg.pixel_doubling) begin
            width_sum = 11'(eff_width) + 11'd14;
            per_row   = 8'(width_sum >> 4);
        end else begin
            width_sum = 11'(eff_width) + 11'd7;
            per_row   = 8'(width_sum >> 3);
        end
        raster_base = 17'(sy) * 17'(per_row);

        // Screen order interleaves the row bits: line in cell, cell row, then third.
        screen_base = {sy[8:6], sy[2:0], sy[5:3], 5'b0};

        o_s1.func      = i_item.func;
        o_s1.value     = i_item.byte_value;
        o_s1.coord_oor = coord_oor;
        o_s1.bit_pos   = (i_cfg.source_layout == LAYOUT_RASTER_LSB) ? sx[2:0] : ~sx[2:0];
        if (i_item.func == FUNC_WRITE) begin
            o_s1.base = SUM_W'(i_item.byte_address);
            o_s1.col  = 6'd0;
        end else begin
            o_s1.base = (i_cfg.source_layout == LAYOUT_SCREEN) ? SUM_W'(screen_base)
                                                               : SUM_W'(raster_base);
            o_s1.col  = sx[8:3];
        end
    end

endmodule
`default_nettype wire

@@ rtl/core/opx_store.sv @@
// Bitmap byte store: single-port synchronous memory with registered read data.
// Depends on opx_pkg for the store depth and the memory request struct.
`default_nettype none
module opx_store
    import opx_pkg::*;
(
    input  wire logic     i_clk,
    input  wire t_mem_req i_req,
    output logic [7:0]    o_rdata
);

    logic [7:0] mem [STORE_BYTES];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            mem[i_req.addr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata <= mem[i_req.addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

@@ rtl/core/one_bit_bitmap_pixel_expander_core.sv @@
// One-bit bitmap pixel expander. Byte writes load the bitmap store; each pixel query returns
// the foreground or background colour of one source bit, with out_of_range set for a
// coordinate outside the image or an address beyond the store. Every request, write or
// query, uses the single store port; one request is accepted per clock unless a stalled
// output holds a query back. Queries pass the stage-one, read and output registers;
// writes yield no result. The store has no reset; an unwritten byte reads as unknown bits.
// Depends on opx_pkg, opx_cfg, opx_addr and opx_store.
`default_nettype none
module one_bit_bitmap_pixel_expander_core
    import opx_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_in_valid,
    output logic                        o_in_ready,
    input  wire t_in_item               i_in_data,
    output logic                        o_out_valid,
    input  wire logic                   i_out_ready,
    output t_out_item                   o_out_data,
    input  wire logic                   i_cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_data
);

    t_cfg       cfg;
    t_s1        s1_next;
    t_s1        r_s1;
    logic       r_s1_valid;
    logic       r_s2_valid;
    logic       r_s2_oor;
    logic [2:0] r_s2_bit_pos;
    logic [7:0] rdata;
    t_mem_req   mem_req;
    t_out_item  r_out;
    logic       r_out_valid;

    logic [SUM_W-1:0] addr_sum;
    logic             addr_oor;
    logic             out_free;
    logic             s2_free;
    logic             s1_move;
    logic             in_accept;
    logic             src_bit;

    opx_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    opx_addr u_addr (
        .i_item (i_in_data),
        .i_cfg  (cfg),
        .o_s1   (s1_next)
    );

    opx_store u_store (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (rdata)
    );

    // Writes retire in the first stage; only queries need room further down.
    always_comb begin
        out_free   = !r_out_valid || i_out_ready;
        s2_free    = !r_s2_valid || out_free;
        s1_move    = r_s1_valid && ((r_s1.func == FUNC_WRITE) || s2_free);
        o_in_ready = !r_s1_valid || s1_move;
        in_accept  = i_in_valid && o_in_ready;

        addr_sum = r_s1.base + SUM_W'(r_s1.col);
        addr_oor = 32'(addr_sum) >= STORE_BYTES;

        mem_req.addr  = addr_sum[ADDR_W-1:0];
        mem_req.wdata = r_s1.value;
        mem_req.we    = r_s1_valid && (r_s1.func == FUNC_WRITE) && !addr_oor;
        mem_req.re    = r_s1_valid && (r_s1.func == FUNC_QUERY) && s2_free;

        src_bit = rdata[r_s2_bit_pos] && !r_s2_oor;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (mem_req.re) begin
                r_s2_valid <= 1'b1;
            end else if (out_free) begin
                r_s2_valid <= 1'b0;
            end
            if (r_s2_valid && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1 <= s1_next;
        end
        if (mem_req.re) begin
            r_s2_oor     <= r_s1.coord_oor || addr_oor;
            r_s2_bit_pos <= r_s1.bit_pos;
        end
        if (r_s2_valid && out_free) begin
            r_out.colour       <= src_bit ? cfg.foreground_colour : cfg.background_colour;
            r_out.bit_set      <= src_bit;
            r_out.out_of_range <= r_s2_oor;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef SYNTHESIS
    a_single_port: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(mem_req.we && mem_req.re))
        else $error("store written and read in the same cycle");

    a_write_retires: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && (r_s1.func == FUNC_WRITE) |-> o_in_ready)
        else $error("write request held up in the first stage");

    a_s2_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2_valid && !out_free |=> r_s2_valid && $stable(r_s2_bit_pos) && $stable(src_bit))
        else $error("stalled query lost its read data");

    a_oor_no_bit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.out_of_range |-> !o_out_data.bit_set)
        else $error("out-of-range result reports a set bit");

    a_stall_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> r_s1_valid && r_s2_valid && r_out_valid)
        else $error("input stalled with a free pipeline slot");
`endif

endmodule
`default_nettype wire

@@ sim/one_bit_bitmap_pixel_expander_core_tb.sv @@
// Self-checking testbench for one_bit_bitmap_pixel_expander_core: byte writes and pixel
// queries with random gaps on both sides, checked against an in-bench pixel predictor.
// Depends on opx_pkg and the core RTL.
module one_bit_bitmap_pixel_expander_core_tb;
    import opx_pkg::*;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_in_valid = 1'b0;
    logic                   o_in_ready;
    t_in_item               i_in_data = '0;
    logic                   o_out_valid;
    logic                   i_out_ready = 1'b0;
    t_out_item              o_out_data;
    logic                   i_cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;

    one_bit_bitmap_pixel_expander_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    localparam int unsigned STALL_CYCLES = 80;

    t_in_item    pending_requests[$];
    t_out_item   expected_pixels[$];
    t_cfg        cur_cfg;
    logic [7:0]  bitmap_model [STORE_BYTES];
    bit          byte_written [STORE_BYTES];
    int          requests_outstanding = 0;
    int          mismatches = 0;
    bit          request_taken = 1'b0;
    bit          steady_traffic = 1'b0;
    bit          stall_request = 1'b0;
    int unsigned stall_left = 0;

    // Returns 1 when the pixel lies outside the image or its byte lies beyond the store.
    function automatic bit locate_pixel(input t_cfg c, input logic [8:0] px, input logic [8:0] py,
                                        output int unsigned addr, output int unsigned bit_pos);
        int unsigned w, sx, sy, per_row, base;
        addr = 0;
        bit_pos = 0;
        w = (c.image_width > MAX_WIDTH) ? MAX_WIDTH : c.image_width;
        if (px >= w || py >= c.image_height) return 1'b1;
        sx = c.pixel_doubling ? (px >> 1) : px;
        sy = c.pixel_doubling ? (py >> 1) : py;
        if (c.source_layout == LAYOUT_SCREEN) begin
            base = (sy & 7) * 256 + (sy & 'h38) * 4 + (sy >> 6) * 2048;
        end else begin
            per_row = c.pixel_doubling ? (w + 14) / 16 : (w + 7) / 8;
            base = sy * per_row;
        end
        addr = base + (sx >> 3);
        if (addr >= STORE_BYTES) return 1'b1;
        bit_pos = (c.source_layout == LAYOUT_RASTER_LSB) ? (sx & 7) : 7 - (sx & 7);
        return 1'b0;
    endfunction

    function automatic t_out_item expected_pixel(input t_in_item req);
        t_out_item   r;
        int unsigned addr, bit_pos;
        r.colour = cur_cfg.background_colour;
        r.bit_set = 1'b0;
        r.out_of_range = 1'b1;
        if (!locate_pixel(cur_cfg, req.pixel_x, req.pixel_y, addr, bit_pos)) begin
            r.bit_set = bitmap_model[addr][bit_pos];
            r.colour = r.bit_set ? cur_cfg.foreground_colour : cur_cfg.background_colour;
            r.out_of_range = 1'b0;
        end
        return r;
    endfunction

    // Sampling at the rising edge: results are checked before new requests are predicted.
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (expected_pixels.size() == 0) begin
                    $error("unexpected result: colour %0d bit_set %0d out_of_range %0d",
                           o_out_data.colour, o_out_data.bit_set, o_out_data.out_of_range);
                    mismatches++;
                end else begin
                    want = expected_pixels.pop_front();
                    if (o_out_data.colour !== want.colour) begin
                        $error("colour: expected %0d, got %0d", want.colour, o_out_data.colour);
                        mismatches++;
                    end
                    if (o_out_data.bit_set !== want.bit_set) begin
                        $error("bit_set: expected %0d, got %0d", want.bit_set,
                               o_out_data.bit_set);
                        mismatches++;
                    end
                    if (o_out_data.out_of_range !== want.out_of_range) begin
                        $error("out_of_range: expected %0d, got %0d", want.out_of_range,
                               o_out_data.out_of_range);
                        mismatches++;
                    end
                end
            end
            request_taken = i_in_valid && o_in_ready;
            if (request_taken) begin
                requests_outstanding--;
                if (i_in_data.func == FUNC_QUERY) begin
                    expected_pixels.push_back(expected_pixel(i_in_data));
                end else if (i_in_data.byte_address < STORE_BYTES) begin
                    bitmap_model[i_in_data.byte_address] = i_in_data.byte_value;
                end
            end
        end
    end

    // Request driver: a new request is offered only once the previous one has been taken.
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_in_valid || request_taken)) begin
            if (pending_requests.size() != 0 && (steady_traffic || $urandom_range(99) >= 19)) begin
                i_in_valid <= 1'b1;
                i_in_data <= pending_requests.pop_front();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (stall_request) begin
            stall_left = STALL_CYCLES;
            stall_request = 1'b0;
        end
        if (stall_left != 0) begin
            stall_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= steady_traffic || $urandom_range(99) >= 19;
        end
    end

    task automatic push_write(input logic [12:0] addr, input logic [7:0] value);
        t_in_item req;
        req.func = FUNC_WRITE;
        req.byte_address = addr;
        req.byte_value = value;
        req.pixel_x = 9'($urandom);
        req.pixel_y = 9'($urandom);
        byte_written[addr] = 1'b1;
        pending_requests.push_back(req);
        requests_outstanding++;
    endtask

    // A query that would read a byte never written gets a write to that byte first.
    task automatic push_query(input logic [8:0] px, input logic [8:0] py);
        t_in_item    req;
        int unsigned addr, bit_pos;
        if (!locate_pixel(cur_cfg, px, py, addr, bit_pos) && !byte_written[addr]) begin
            push_write(addr[12:0], 8'($urandom));
        end
        req.func = FUNC_QUERY;
        req.byte_address = 13'($urandom);
        req.byte_value = 8'($urandom);
        req.pixel_x = px;
        req.pixel_y = py;
        pending_requests.push_back(req);
        requests_outstanding++;
    endtask

    // Waits until every request is taken and answered, then lets trailing writes settle.
    task automatic drain();
        while (requests_outstanding != 0 || expected_pixels.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        case (idx)
            CFG_IMAGE_WIDTH:   cur_cfg.image_width = data;
            CFG_IMAGE_HEIGHT:  cur_cfg.image_height = data;
            CFG_PIXEL_DOUBLE:  cur_cfg.pixel_doubling = data[0];
            CFG_SOURCE_LAYOUT: cur_cfg.source_layout = data[1:0];
            CFG_FG_COLOUR:     cur_cfg.foreground_colour = data[7:0];
            CFG_BG_COLOUR:     cur_cfg.background_colour = data[7:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Unused upper data bits carry noise; the block must ignore them.
    task automatic set_config(input logic [9:0] w, input logic [9:0] h, input logic dbl,
                              input logic [1:0] layout, input logic [7:0] fg,
                              input logic [7:0] bg);
        drain();
        write_reg(CFG_IMAGE_WIDTH, w);
        write_reg(CFG_IMAGE_HEIGHT, h);
        write_reg(CFG_PIXEL_DOUBLE, {9'($urandom), dbl});
        write_reg(CFG_SOURCE_LAYOUT, {8'($urandom), layout});
        write_reg(CFG_FG_COLOUR, {2'($urandom), fg});
        write_reg(CFG_BG_COLOUR, {2'($urandom), bg});
    endtask

    task automatic run_random(input int count);
        int unsigned lim_x, lim_y;
        lim_x = (cur_cfg.image_width > MAX_WIDTH) ? MAX_WIDTH : cur_cfg.image_width;
        lim_y = (cur_cfg.image_height > 512) ? 512 : cur_cfg.image_height;
        push_query(9'd0, 9'd0);
        push_query(9'(lim_x - 1), 9'(lim_y - 1));
        push_query(9'(lim_x), 9'd0);
        push_query(9'd0, 9'(lim_y));
        repeat (count) begin
            case ($urandom_range(9))
                0, 1: push_write(13'($urandom), 8'($urandom));
                2:    push_write(13'($urandom_range(1023)), 8'($urandom));
                3:    push_query(9'($urandom), 9'($urandom));
                default: begin
                    if (lim_x == 0 || lim_y == 0) begin
                        push_query(9'($urandom), 9'($urandom));
                    end else begin
                        push_query(9'($urandom_range(lim_x - 1)), 9'($urandom_range(lim_y - 1)));
                    end
                end
            endcase
        end
    endtask

    initial begin
        cur_cfg = '{image_width: 10'd256, image_height: 10'd192, pixel_doubling: 1'b0,
                    source_layout: LAYOUT_RASTER_MSB, foreground_colour: 8'd0,
                    background_colour: 8'd7};
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed requests under the reset settings.
        push_write(13'd0, 8'hFF);
        push_write(13'd8191, 8'h00);
        push_write(13'd8191, 8'hFF);
        push_write(13'd31, 8'h01);
        push_query(9'd0, 9'd0);
        push_query(9'd7, 9'd0);
        push_query(9'd8, 9'd0);
        push_query(9'd255, 9'd0);
        push_query(9'd255, 9'd191);
        push_query(9'd256, 9'd0);
        push_query(9'd0, 9'd192);
        push_query(9'd511, 9'd511);
        push_write(13'd0, 8'h5A);
        push_query(9'd1, 9'd0);
        push_query(9'd2, 9'd0);
        push_write(13'd0, 8'h00);
        push_query(9'd1, 9'd0);
        drain();

        set_config(10'd512, 10'd512, 1'b0, LAYOUT_RASTER_MSB, 8'hFF, 8'h00);
        run_random(110);

        // A stretch where neither side idles.
        drain();
        steady_traffic = 1'b1;
        set_config(10'd100, 10'd50, 1'b0, LAYOUT_RASTER_LSB, 8'h3C, 8'hC3);
        run_random(90);
        drain();
        steady_traffic = 1'b0;

        // The receiver holds off while requests keep coming, so the block backs up.
        set_config(10'd256, 10'd192, 1'b0, LAYOUT_SCREEN, 8'h81, 8'h7E);
        stall_request = 1'b1;
        run_random(90);

        set_config(10'd512, 10'd384, 1'b1, LAYOUT_SCREEN, 8'h12, 8'h34);
        run_random(90);
        // Screen rows past the store end up beyond the last byte.
        set_config(10'd256, 10'd512, 1'b0, LAYOUT_SCREEN, 8'h55, 8'hAA);
        run_random(80);
        // Width beyond the maximum saturates; layout three reads as raster MSB first.
        set_config(10'd1023, 10'd1023, 1'b0, 2'd3, 8'hF0, 8'h0F);
        run_random(80);
        set_config(10'd0, 10'd100, 1'b0, LAYOUT_RASTER_MSB, 8'h01, 8'h02);
        run_random(30);
        set_config(10'd100, 10'd0, 1'b1, LAYOUT_SCREEN, 8'h03, 8'h04);
        run_random(30);
        set_config(10'd1, 10'd1, 1'b1, LAYOUT_RASTER_MSB, 8'hFF, 8'hFE);
        run_random(20);
        set_config(10'd17, 10'd9, 1'b1, LAYOUT_RASTER_LSB, 8'h99, 8'h66);
        run_random(60);

        repeat (6) begin
            set_config(($urandom_range(3) == 0) ? 10'($urandom) : 10'($urandom_range(1, 512)),
                       ($urandom_range(3) == 0) ? 10'($urandom) : 10'($urandom_range(1, 512)),
                       1'($urandom), 2'($urandom), 8'($urandom), 8'($urandom));
            run_random(50);
        end

        drain();
        if (mismatches == 0 && expected_pixels.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
